// ===== hdl/pfx_pkg.sv =====
`default_nettype none

package pfx_pkg;

    // Default number of operand stack entries.
    localparam int STACK_DEPTH = 16;

    // Entries in the queue between the character front end and the stack engine.
    localparam int QUEUE_DEPTH = 4;

    // Character codes that the front end recognizes.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;

    // Classified operation of one character.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_DIGIT,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_POW
    } t_op;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_UNDER = 3'd1,
        ST_OVER  = 3'd2,
        ST_DIVZ  = 3'd3,
        ST_DEPTH = 3'd4
    } t_status;

    // One classified item as it travels through the queue.
    typedef struct packed {
        t_op        op;
        logic [3:0] digit;
        logic       last;
    } t_item;

    // Stack engine states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_DIV,
        S_DIV_FIN,
        S_POW,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/postfix_expression_evaluator.sv =====
`default_nettype none

// Postfix expression evaluator. Characters enter one per item; digits push 0..9,
// + - * / ^ combine the two top entries in 32-bit wrapping arithmetic, other
// characters are ignored, and an item marked last produces one result (value and
// status) and clears the stack. A front end classifies characters at up to one
// item per cycle into a four-entry queue while that queue is not full; the stack
// engine behind it takes a digit directly, fetches the lower operand for + - * /
// and ^, settles a divide by zero or a negative exponent at that fetch, runs a
// restoring divider for any other divide (one quotient bit per cycle) and a
// square-and-multiply loop for any other power (one exponent bit per cycle). A
// closing item then loads the output register once the previous result is taken;
// further items are taken into the queue while a result waits there.
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_ch,
    input  wire logic        i_last,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_value,
    output logic [2:0]       o_status
);

    logic           push;
    logic           full;
    logic           q_valid;
    logic           q_pop;
    pfx_pkg::t_item front_item;
    pfx_pkg::t_item q_item;

    pfx_front u_front (
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_ch    (i_ch),
        .i_last  (i_last),
        .i_full  (full),
        .o_push  (push),
        .o_item  (front_item)
    );

    pfx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_item)
    );

    pfx_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_valid),
        .i_item       (q_item),
        .o_item_pop   (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_value      (o_value),
        .o_status     (o_status)
    );

endmodule

`default_nettype wire

// ===== hdl/pfx_front.sv =====
`default_nettype none

module pfx_front (
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_ch,
    input  wire logic          i_last,
    input  wire logic          i_full,
    output logic               o_push,
    output pfx_pkg::t_item     o_item
);

    pfx_pkg::t_op op;
    logic [7:0]   digit_full;

    // Map the character onto an operation; everything unknown is a no-op.
    always_comb begin
        digit_full = i_ch - pfx_pkg::CH_ZERO;
        op         = pfx_pkg::OP_NOP;
        if (i_ch >= pfx_pkg::CH_ZERO && i_ch <= pfx_pkg::CH_NINE) begin
            op = pfx_pkg::OP_DIGIT;
        end else if (i_ch == pfx_pkg::CH_PLUS) begin
            op = pfx_pkg::OP_ADD;
        end else if (i_ch == pfx_pkg::CH_MINUS) begin
            op = pfx_pkg::OP_SUB;
        end else if (i_ch == pfx_pkg::CH_STAR) begin
            op = pfx_pkg::OP_MUL;
        end else if (i_ch == pfx_pkg::CH_SLASH) begin
            op = pfx_pkg::OP_DIV;
        end else if (i_ch == pfx_pkg::CH_CARET) begin
            op = pfx_pkg::OP_POW;
        end
    end

    // An ignored character that does not close the expression never enters the queue.
    assign o_ready      = !i_full;
    assign o_push       = i_valid && !i_full && (op != pfx_pkg::OP_NOP || i_last);
    assign o_item.op    = op;
    assign o_item.digit = digit_full[3:0];
    assign o_item.last  = i_last;

endmodule

`default_nettype wire

// ===== hdl/pfx_queue.sv =====
`default_nettype none

module pfx_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire pfx_pkg::t_item i_item,
    output logic                o_full,
    output logic                o_valid,
    input  wire logic           i_pop,
    output pfx_pkg::t_item      o_item
);

    localparam int QAW = $clog2(pfx_pkg::QUEUE_DEPTH);
    localparam int QCW = $clog2(pfx_pkg::QUEUE_DEPTH + 1);

    pfx_pkg::t_item r_mem [pfx_pkg::QUEUE_DEPTH];
    logic [QAW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCW-1:0] r_count, n_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == QCW'(pfx_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill count update with explicit wrap.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QAW'(pfx_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QAW'(pfx_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Item storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pfx_back.sv =====
`default_nettype none

module pfx_back #(
    parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_item_valid,
    input  wire pfx_pkg::t_item i_item,
    output logic                o_item_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [31:0]         o_value,
    output logic [2:0]          o_status
);

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // Control state.
    pfx_pkg::t_state  r_state, n_state;
    logic [DW-1:0]    r_depth, n_depth;
    pfx_pkg::t_status r_err, n_err;
    logic             r_out_valid, n_out_valid;

    // Datapath state.
    logic [31:0]      r_tos, n_tos;
    pfx_pkg::t_op     r_op, n_op;
    logic             r_last, n_last;
    logic [31:0]      r_acc, n_acc;
    logic [31:0]      r_base, n_base;
    logic [31:0]      r_ex, n_ex;
    logic [31:0]      r_quo, n_quo;
    logic [31:0]      r_rem, n_rem;
    logic [31:0]      r_dvs, n_dvs;
    logic             r_neg, n_neg;
    logic [4:0]       r_cnt, n_cnt;
    logic [31:0]      r_out_value, n_out_value;
    pfx_pkg::t_status r_out_status, n_out_status;

    // Operand stack below the top entry; the top entry lives in r_tos.
    logic [31:0]      r_stack [STACK_DEPTH];
    logic [31:0]      r_rd_data;
    logic [DW-1:0]    rd_full;
    logic [DW-1:0]    wr_full;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic             mem_we;

    logic [31:0]      mul_x, mul_y, prod_a, prod_b;
    logic [32:0]      trial;
    logic [32:0]      trial_diff;
    pfx_pkg::t_state  done_state;
    logic             out_load;

    assign rd_full    = r_depth - DW'(2);
    assign wr_full    = r_depth - DW'(1);
    assign rd_addr    = rd_full[AW-1:0];
    assign wr_addr    = wr_full[AW-1:0];
    assign done_state = r_last ? pfx_pkg::S_EMIT : pfx_pkg::S_IDLE;
    assign out_load   = (r_state == pfx_pkg::S_EMIT) && (!r_out_valid || i_ready);

    // Multiply and the power loop's accumulator share prod_a; the loop squares the base in prod_b.
    always_comb begin
        if (r_state == pfx_pkg::S_POW) begin
            mul_x = r_acc;
            mul_y = r_base;
        end else begin
            mul_x = r_rd_data;
            mul_y = r_tos;
        end
        prod_a = mul_x * mul_y;
        prod_b = r_base * r_base;
    end

    // One restoring divide step on magnitudes.
    assign trial      = {r_rem, r_quo[31]};
    assign trial_diff = trial - {1'b0, r_dvs};

    // Next state and datapath.
    always_comb begin
        n_state      = r_state;
        n_depth      = r_depth;
        n_err        = r_err;
        n_tos        = r_tos;
        n_op         = r_op;
        n_last       = r_last;
        n_acc        = r_acc;
        n_base       = r_base;
        n_ex         = r_ex;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_dvs        = r_dvs;
        n_neg        = r_neg;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        mem_we       = 1'b0;
        o_item_pop   = 1'b0;
        case (r_state)
            pfx_pkg::S_IDLE: begin
                if (i_item_valid) begin
                    o_item_pop = 1'b1;
                    n_op       = i_item.op;
                    n_last     = i_item.last;
                    n_state    = i_item.last ? pfx_pkg::S_EMIT : pfx_pkg::S_IDLE;
                    // After an error every character up to the last one is skipped.
                    if (r_err == pfx_pkg::ST_OK) begin
                        case (i_item.op)
                            pfx_pkg::OP_NOP: begin
                            end
                            pfx_pkg::OP_DIGIT: begin
                                if (r_depth >= DW'(STACK_DEPTH)) begin
                                    n_err = pfx_pkg::ST_OVER;
                                end else begin
                                    mem_we  = (r_depth != '0);
                                    n_tos   = {28'd0, i_item.digit};
                                    n_depth = r_depth + 1'b1;
                                end
                            end
                            pfx_pkg::OP_ADD, pfx_pkg::OP_SUB, pfx_pkg::OP_MUL,
                            pfx_pkg::OP_DIV, pfx_pkg::OP_POW: begin
                                if (r_depth < DW'(2)) begin
                                    n_err = pfx_pkg::ST_UNDER;
                                end else begin
                                    n_state = pfx_pkg::S_FETCH;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            pfx_pkg::S_FETCH: begin
                // r_rd_data holds the lower operand, r_tos the upper one.
                n_state = done_state;
                case (r_op)
                    pfx_pkg::OP_ADD: begin
                        n_tos   = r_rd_data + r_tos;
                        n_depth = r_depth - 1'b1;
                    end
                    pfx_pkg::OP_SUB: begin
                        n_tos   = r_rd_data - r_tos;
                        n_depth = r_depth - 1'b1;
                    end
                    pfx_pkg::OP_MUL: begin
                        n_tos   = prod_a;
                        n_depth = r_depth - 1'b1;
                    end
                    pfx_pkg::OP_DIV: begin
                        if (r_tos == '0) begin
                            n_err = pfx_pkg::ST_DIVZ;
                        end else begin
                            n_quo   = r_rd_data[31] ? (32'd0 - r_rd_data) : r_rd_data;
                            n_dvs   = r_tos[31] ? (32'd0 - r_tos) : r_tos;
                            n_rem   = '0;
                            n_neg   = r_rd_data[31] ^ r_tos[31];
                            n_cnt   = '0;
                            n_state = pfx_pkg::S_DIV;
                        end
                    end
                    pfx_pkg::OP_POW: begin
                        if (r_tos[31]) begin
                            // Negative exponent: only bases of one and minus one survive.
                            n_depth = r_depth - 1'b1;
                            if (r_rd_data == 32'd1) begin
                                n_tos = 32'd1;
                            end else if (r_rd_data == 32'hFFFF_FFFF) begin
                                n_tos = r_tos[0] ? 32'hFFFF_FFFF : 32'd1;
                            end else begin
                                n_tos = '0;
                            end
                        end else begin
                            n_acc   = 32'd1;
                            n_base  = r_rd_data;
                            n_ex    = r_tos;
                            n_state = pfx_pkg::S_POW;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            pfx_pkg::S_DIV: begin
                if (!trial_diff[32]) begin
                    n_rem = trial_diff[31:0];
                    n_quo = {r_quo[30:0], 1'b1};
                end else begin
                    n_rem = trial[31:0];
                    n_quo = {r_quo[30:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 5'd31) begin
                    n_state = pfx_pkg::S_DIV_FIN;
                end
            end
            pfx_pkg::S_DIV_FIN: begin
                n_tos   = r_neg ? (32'd0 - r_quo) : r_quo;
                n_depth = r_depth - 1'b1;
                n_state = done_state;
            end
            pfx_pkg::S_POW: begin
                // Square and multiply, one exponent bit per cycle.
                if (r_ex == '0) begin
                    n_tos   = r_acc;
                    n_depth = r_depth - 1'b1;
                    n_state = done_state;
                end else begin
                    if (r_ex[0]) begin
                        n_acc = prod_a;
                    end
                    n_base = prod_b;
                    n_ex   = {1'b0, r_ex[31:1]};
                end
            end
            pfx_pkg::S_EMIT: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    if (r_err != pfx_pkg::ST_OK) begin
                        n_out_value  = '0;
                        n_out_status = r_err;
                    end else if (r_depth != DW'(1)) begin
                        n_out_value  = '0;
                        n_out_status = pfx_pkg::ST_DEPTH;
                    end else begin
                        n_out_value  = r_tos;
                        n_out_status = pfx_pkg::ST_OK;
                    end
                    n_depth = '0;
                    n_err   = pfx_pkg::ST_OK;
                    n_state = pfx_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pfx_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfx_pkg::S_IDLE;
            r_depth     <= '0;
            r_err       <= pfx_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_tos        <= n_tos;
        r_op         <= n_op;
        r_last       <= n_last;
        r_acc        <= n_acc;
        r_base       <= n_base;
        r_ex         <= n_ex;
        r_quo        <= n_quo;
        r_rem        <= n_rem;
        r_dvs        <= n_dvs;
        r_neg        <= n_neg;
        r_cnt        <= n_cnt;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    // Stack memory: the old top is pushed down on a digit, the lower operand is read back.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_stack[wr_addr] <= r_tos;
        end
        r_rd_data <= r_stack[rd_addr];
    end

    assign o_valid  = r_out_valid;
    assign o_value  = r_out_value;
    assign o_status = r_out_status;

    // The depth count never passes the stack size.
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(STACK_DEPTH))
        else $error("stack depth beyond stack size");

    // An operand fetch always follows a dispatch from idle.
    a_fetch_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pfx_pkg::S_FETCH |-> $past(r_state) == pfx_pkg::S_IDLE)
        else $error("operand fetch without dispatch");

    // Divide sign fix only after the full run of divide steps.
    a_div_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pfx_pkg::S_DIV_FIN |-> $past(r_state) == pfx_pkg::S_DIV
                                          && $past(r_cnt) == 5'd31)
        else $error("divide finished early");

    // A kept error parks the engine until the closing item.
    a_err_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err != pfx_pkg::ST_OK |-> r_state == pfx_pkg::S_IDLE
                                    || r_state == pfx_pkg::S_EMIT)
        else $error("engine busy with an error pending");

    // Emitting a result leaves an empty, error-free stack.
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_depth == '0 && r_err == pfx_pkg::ST_OK && r_out_valid)
        else $error("stack not cleared after result");

endmodule

`default_nettype wire

// ===== tb/postfix_expression_evaluator_checker.sv =====
`default_nettype none

// Watches both channels of the evaluator, keeps its own copy of the operand
// stack and compares every result item with the oldest outcome still awaited.
module postfix_expression_evaluator_checker #(
    parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        o_ready,
    input  wire logic [7:0]  i_ch,
    input  wire logic        i_last,
    input  wire logic        o_valid,
    input  wire logic        i_ready,
    input  wire logic [31:0] o_value,
    input  wire logic [2:0]  o_status,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [31:0]      value;
        pfx_pkg::t_status status;
    } t_outcome;

    // Shadow of the evaluator state.
    logic [31:0]      operands [STACK_DEPTH];
    int unsigned      level;
    pfx_pkg::t_status fault;
    t_outcome         awaited_outcomes[$];
    int               mismatches = 0;

    // Maps one character onto the operation it stands for.
    function automatic pfx_pkg::t_op classify(logic [7:0] c);
        if (c >= pfx_pkg::CH_ZERO && c <= pfx_pkg::CH_NINE) return pfx_pkg::OP_DIGIT;
        case (c)
            pfx_pkg::CH_PLUS:  return pfx_pkg::OP_ADD;
            pfx_pkg::CH_MINUS: return pfx_pkg::OP_SUB;
            pfx_pkg::CH_STAR:  return pfx_pkg::OP_MUL;
            pfx_pkg::CH_SLASH: return pfx_pkg::OP_DIV;
            pfx_pkg::CH_CARET: return pfx_pkg::OP_POW;
            default:           return pfx_pkg::OP_NOP;
        endcase
    endfunction

    // Signed division that truncates toward zero, done on magnitudes.
    function automatic logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] ^ b[31]) ? -q : q;
    endfunction

    // Wrapping integer power; a negative exponent only survives for bases 1 and -1.
    function automatic logic [31:0] power(logic [31:0] base, logic [31:0] ex);
        logic [31:0] acc;
        acc = 32'd1;
        if (ex[31]) begin
            if (base == 32'd1) return 32'd1;
            if (base == 32'hFFFF_FFFF) return ex[0] ? 32'hFFFF_FFFF : 32'd1;
            return 32'd0;
        end
        while (ex != 32'd0) begin
            if (ex[0]) acc = acc * base;
            base = base * base;
            ex = ex >> 1;
        end
        return acc;
    endfunction

    // Applies one accepted character and, on a closing item, queues the outcome.
    task automatic evaluate_char(input logic [7:0] c, input logic closing);
        pfx_pkg::t_op op;
        logic [31:0]  a;
        logic [31:0]  b;
        logic [31:0]  r;
        t_outcome     outcome;
        op = classify(c);
        if (fault == pfx_pkg::ST_OK) begin
            if (op == pfx_pkg::OP_DIGIT) begin
                if (level >= STACK_DEPTH) begin
                    fault = pfx_pkg::ST_OVER;
                end else begin
                    operands[level] = {24'h0, c - pfx_pkg::CH_ZERO};
                    level++;
                end
            end else if (op != pfx_pkg::OP_NOP) begin
                if (level < 2) begin
                    fault = pfx_pkg::ST_UNDER;
                end else begin
                    a = operands[level - 2];
                    b = operands[level - 1];
                    r = 32'd0;
                    case (op)
                        pfx_pkg::OP_ADD: r = a + b;
                        pfx_pkg::OP_SUB: r = a - b;
                        pfx_pkg::OP_MUL: r = a * b;
                        pfx_pkg::OP_DIV: begin
                            if (b == 32'd0) fault = pfx_pkg::ST_DIVZ;
                            else r = quotient(a, b);
                        end
                        pfx_pkg::OP_POW: r = power(a, b);
                        default: ;
                    endcase
                    if (fault == pfx_pkg::ST_OK) begin
                        operands[level - 2] = r;
                        level--;
                    end
                end
            end
        end
        if (closing) begin
            outcome.value = 32'd0;
            if (fault != pfx_pkg::ST_OK) begin
                outcome.status = fault;
            end else if (level != 1) begin
                outcome.status = pfx_pkg::ST_DEPTH;
            end else begin
                outcome.status = pfx_pkg::ST_OK;
                outcome.value = operands[0];
            end
            awaited_outcomes.insert(awaited_outcomes.size(), outcome);
            level = 0;
            fault = pfx_pkg::ST_OK;
        end
    endtask

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // Compares one result item with the oldest awaited outcome.
    task automatic check_outcome();
        t_outcome want;
        if (awaited_outcomes.size() == 0) begin
            report_mismatch("unexpected result item", o_value, 32'd0);
            return;
        end
        want = awaited_outcomes.pop_front();
        if (o_value !== want.value) report_mismatch("value", o_value, want.value);
        if (o_status !== want.status) report_mismatch("status", {29'd0, o_status},
                                                     {29'd0, want.status});
    endtask

    // Results are checked before the input of the same edge is applied.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            level = 0;
            fault = pfx_pkg::ST_OK;
            awaited_outcomes.delete();
        end else begin
            if (o_valid && i_ready) check_outcome();
            if (i_valid && o_ready) evaluate_char(i_ch, i_last);
        end
        o_pending <= awaited_outcomes.size();
        o_fail_count <= mismatches;
    end

endmodule

`default_nettype wire

// ===== tb/tb_postfix_expression_evaluator.sv =====
`default_nettype none

// Drives expression characters into the evaluator and gives the verdict; the
// checker beside the block predicts and compares the results.
module tb_postfix_expression_evaluator;

    localparam int ITEM_TARGET = 550;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 80;
    localparam logic [7:0] OPERATORS [5] = '{pfx_pkg::CH_PLUS, pfx_pkg::CH_MINUS,
                                             pfx_pkg::CH_STAR, pfx_pkg::CH_SLASH,
                                             pfx_pkg::CH_CARET};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_ch;
    logic        i_last;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_value;
    logic [2:0]  o_status;

    int          fail_count;
    int          pending;
    int unsigned counted_items = 0;
    int          expr_index = 0;
    int          quiet_cycles = 0;
    bit          steady = 1'b0;
    logic [7:0]  expr_q[$];

    postfix_expression_evaluator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_ch     (i_ch),
        .i_last   (i_last),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_value  (o_value),
        .o_status (o_status)
    );

    postfix_expression_evaluator_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_ch         (i_ch),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_value      (o_value),
        .o_status     (o_status),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock with a period of 10.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle lengths: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic bit is_active_char(logic [7:0] c);
        return (c >= pfx_pkg::CH_ZERO && c <= pfx_pkg::CH_NINE) ||
               c == pfx_pkg::CH_PLUS || c == pfx_pkg::CH_MINUS ||
               c == pfx_pkg::CH_STAR || c == pfx_pkg::CH_SLASH || c == pfx_pkg::CH_CARET;
    endfunction

    // A character that the evaluator ignores.
    function automatic logic [7:0] filler_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (is_active_char(c)) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] random_op();
        return OPERATORS[$urandom_range(0, 4)];
    endfunction

    // Result side: random stalls of the receiver.
    initial begin
        int hold;
        i_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            hold = pick_gap();
            if (hold > 0) begin
                i_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Ends the run when no item moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[postfix_expression_evaluator] ERROR");
            $finish;
        end
    end

    task automatic hold_off(input int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Presents one item and waits until it is accepted.
    task automatic send_item(input logic [7:0] c, input logic l);
        i_valid <= 1'b1;
        i_ch <= c;
        i_last <= l;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (l || is_active_char(c)) counted_items++;
        hold_off(pick_gap());
    endtask

    // Sends the built expression; the final character closes it if asked.
    task automatic send_expr(input logic closing);
        for (int i = 0; i < expr_q.size(); i++)
            send_item(expr_q[i], closing && (i == expr_q.size() - 1));
        expr_q.delete();
    endtask

    // Holds the sender until every awaited result has come back.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Appends one character to the expression being built.
    task automatic append_char(input logic [7:0] c);
        expr_q.insert(expr_q.size(), c);
    endtask

    task automatic push_digit(input int d);
        append_char(pfx_pkg::CH_ZERO + 8'(d));
    endtask

    task automatic push_op(input logic [7:0] c);
        append_char(c);
    endtask

    // Builds 2 ^ 31, the most negative value.
    task automatic push_int_min();
        push_digit(2);
        push_digit(5);
        push_digit(6);
        push_op(pfx_pkg::CH_STAR);
        push_digit(1);
        push_op(pfx_pkg::CH_PLUS);
        push_op(pfx_pkg::CH_CARET);
    endtask

    // A well-formed expression with random digits and operators.
    task automatic add_well_formed();
        int n_dig;
        int depth;
        int pushed;
        n_dig = $urandom_range(1, 8);
        depth = 0;
        pushed = 0;
        while (pushed < n_dig || depth > 1) begin
            if (pushed < n_dig && (depth < 2 || $urandom_range(0, 1) == 1)) begin
                push_digit($urandom_range(0, 9));
                depth++;
                pushed++;
            end else begin
                push_op(random_op());
                depth--;
            end
            if ($urandom_range(0, 9) == 0) append_char(filler_char());
        end
    endtask

    // Damages an expression: drops a character, adds an operator or a digit.
    task automatic break_expr();
        case ($urandom_range(0, 2))
            0: expr_q.delete($urandom_range(0, expr_q.size() - 1));
            1: expr_q.insert($urandom_range(0, expr_q.size()), random_op());
            default: push_digit($urandom_range(0, 9));
        endcase
    endtask

    // Corner cases of the stack and of the arithmetic.
    task automatic add_special();
        int n;
        case ($urandom_range(0, 6))
            0: begin
                // Stack overflow, sometimes with operators behind it.
                n = $urandom_range(17, 19);
                repeat (n) push_digit($urandom_range(0, 9));
                repeat ($urandom_range(0, 3)) push_op(random_op());
            end
            1: begin
                // Full stack, then folded down to one entry.
                repeat (pfx_pkg::STACK_DEPTH) push_digit($urandom_range(0, 9));
                repeat (pfx_pkg::STACK_DEPTH - 1) push_op(random_op());
            end
            2: begin
                // Most negative value divided by minus one.
                push_int_min();
                push_digit(0);
                push_digit(1);
                push_op(pfx_pkg::CH_MINUS);
                push_op(pfx_pkg::CH_SLASH);
            end
            3: begin
                // Base minus one with a negative exponent.
                push_digit(0);
                push_digit(1);
                push_op(pfx_pkg::CH_MINUS);
                push_digit(0);
                push_digit($urandom_range(1, 9));
                push_op(pfx_pkg::CH_MINUS);
                push_op(pfx_pkg::CH_CARET);
            end
            4: begin
                // Base one or another base with a negative exponent.
                push_digit($urandom_range(0, 9));
                push_digit(0);
                push_digit($urandom_range(1, 9));
                push_op(pfx_pkg::CH_MINUS);
                push_op(pfx_pkg::CH_CARET);
            end
            5: begin
                // Zero exponent, base zero included.
                push_digit($urandom_range(0, 9));
                push_digit(0);
                push_op(pfx_pkg::CH_CARET);
            end
            default: begin
                // Arithmetic on the most negative value.
                push_int_min();
                push_digit($urandom_range(0, 9));
                push_op(random_op());
            end
        endcase
    endtask

    // Stimulus.
    initial begin
        int pick;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_ch <= 8'h00;
        i_last <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Add and multiply.
        push_digit(9);
        push_digit(8);
        push_op(pfx_pkg::CH_STAR);
        push_digit(3);
        push_op(pfx_pkg::CH_PLUS);
        send_expr(1'b1);
        // Negative operand and division truncating toward zero.
        push_digit(0);
        push_digit(7);
        push_op(pfx_pkg::CH_MINUS);
        push_digit(2);
        push_op(pfx_pkg::CH_SLASH);
        send_expr(1'b1);
        // Power.
        push_digit(2);
        push_digit(3);
        push_op(pfx_pkg::CH_CARET);
        send_expr(1'b1);
        // Underflow on the first character.
        push_op(pfx_pkg::CH_PLUS);
        send_expr(1'b1);
        // Divide by zero.
        push_digit(5);
        push_digit(0);
        push_op(pfx_pkg::CH_SLASH);
        send_expr(1'b1);
        // Two entries left at the end.
        push_digit(1);
        push_digit(2);
        send_expr(1'b1);
        // Negative exponent on base two.
        push_digit(2);
        push_digit(0);
        push_digit(1);
        push_op(pfx_pkg::CH_MINUS);
        push_op(pfx_pkg::CH_CARET);
        send_expr(1'b1);
        // The first error is kept; the digit behind it is ignored.
        push_op(pfx_pkg::CH_PLUS);
        push_digit(5);
        send_expr(1'b1);
        // An ignored character alone closes an empty expression.
        append_char(8'hFF);
        send_expr(1'b1);
        wait_for_results();

        // Random expressions, with stretches free of idling.
        while (counted_items < ITEM_TARGET) begin
            steady = (expr_index % 30) >= 24;
            if (expr_index == 35) wait_for_results();
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                add_well_formed();
                if ($urandom_range(0, 6) == 0) append_char(filler_char());
                send_expr(1'b1);
            end else if (pick < 74) begin
                add_well_formed();
                break_expr();
                send_expr(1'b1);
            end else if (pick < 88) begin
                add_special();
                send_expr(1'b1);
            end else begin
                repeat ($urandom_range(1, 6)) append_char(8'($urandom_range(0, 255)));
                send_expr(1'($urandom_range(0, 1)));
            end
            expr_index++;
        end
        steady = 1'b0;

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[postfix_expression_evaluator] OK");
        end else begin
            $display("[postfix_expression_evaluator] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
